// File: rtl/assert_macros.svh
// Assertion macros shared by the envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LARE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("envelope assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LARE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("envelope assertion failed");

`endif

// File: rtl/lare_pkg.sv
// Types, constants and constant tables for the looping attack/release envelope.
package lare_pkg;

    localparam int FRAC_BITS = 24;
    localparam int LVL_W     = FRAC_BITS + 2;
    localparam int MULT_W    = 24;

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(2) << FRAC_BITS;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << FRAC_BITS;

    localparam logic [MULT_W-1:0] ADOPT_CAP   = 24'd16768827;
    localparam logic [MULT_W-1:0] MULT_SAT    = 24'hFFFFFF;
    localparam logic [13:0]       DRIFT_SCALE = 14'd9830;

    localparam logic [23:0] ATTACK_RST  = 24'd16760438;
    localparam logic [23:0] RELEASE_RST = 24'd16760438;
    localparam logic [24:0] SILENCE_RST = 25'd17;
    localparam logic [23:0] QUICK_RST   = 24'd16693529;
    localparam logic [31:0] SEED_RST    = 32'd2463534242;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_ATTACK  = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_RESET   = 3'd3,
        ACT_QUICK   = 3'd4,
        ACT_ADOPT   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_RELEASE = 3'd1,
        REG_DRIFT   = 3'd2,
        REG_LOOP    = 3'd3,
        REG_SILENCE = 3'd4,
        REG_QUICK   = 3'd5,
        REG_SEED    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        STAGE_IDLE    = 2'd0,
        STAGE_ATTACK  = 2'd1,
        STAGE_RELEASE = 2'd2
    } stage_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_MUL,
        ST_TICK_FIN,
        ST_DR_START,
        ST_DR_DEPTH,
        ST_DR_RD,
        ST_DR_NORM,
        ST_DR_LOG,
        ST_DR_PROD,
        ST_DR_EXP,
        ST_DR_FIN,
        ST_DR_APPLY,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] new_release_mult;
    } in_item_t;

    typedef struct packed {
        logic [25:0] level_out;
        logic [1:0]  stage_out;
        logic        active;
        logic        in_attack;
    } out_item_t;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] seed;
    } rng_ctl_t;

    typedef logic [29:0] root_tab_t [16];

    // Floor integer square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bt;
        begin
            rem = v;
            res = '0;
            bt  = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (rem >= res + bt) begin
                    rem = rem - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        end
    endfunction

    // Factors 2^(-2^-(k+1)) in Q0.30, each the root of the one before.
    function automatic root_tab_t exp_roots();
        root_tab_t   t;
        logic [63:0] c;
        begin
            c = 64'd1 << 29;
            for (int k = 0; k < 16; k++) begin
                c    = isqrt64(c << 30);
                t[k] = c[29:0];
            end
            return t;
        end
    endfunction

    localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

// File: rtl/lare_mul.sv
// Shared 32 by 32 unsigned multiplier used by the tick and drift products.
module lare_mul
    import lare_pkg::*;
(
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    assign prod = 64'(op_a) * 64'(op_b);

endmodule

// File: rtl/lare_rng.sv
// Xorshift32 generator with seed load and single-step advance.
module lare_rng
    import lare_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rng_ctl_t    ctl,
    output logic [31:0] rnd_next
);

    logic [31:0] state_reg;
    logic [31:0] s1;
    logic [31:0] s2;

    always_comb begin
        s1       = state_reg ^ (state_reg << 13);
        s2       = s1 ^ (s1 >> 17);
        rnd_next = s2 ^ (s2 << 5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RST;
        end else if (ctl.load) begin
            state_reg <= ctl.seed;
        end else if (ctl.step) begin
            state_reg <= rnd_next;
        end
    end

endmodule

// File: rtl/looping_ar_envelope_with_drift.sv
// Top level of the looping attack/release envelope with random pole drift.
//
//  channel   direction  ports                         beat carries
//  s_        in         s_valid  s_ready  s_data      action, new_release_mult
//  m_        out        m_valid  m_ready  m_data      level_out, stage_out, active, in_attack
//  cfg_      in         cfg_wr_en cfg_addr cfg_wdata  one register write, no wait
//
// A beat without drift work (tick that changes no stage, reset, quick release) goes from
// idle to the final state, a tick by way of its multiply and finish states. Each drifted
// pole runs a normalize loop, 16 squarings and 16 exp2 products on the shared multiplier;
// a tick that ends an attack at or below the silence level with looping on runs two.
// Reset is synchronous and active low and needs no clearing pass.
// The block takes a new beat only when its sequencer is idle; a result that waits on
// m_ready holds the sequencer in its final state until the output register frees.
`include "assert_macros.svh"

module looping_ar_envelope_with_drift
    import lare_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    // Configuration registers.
    logic [23:0] attack_reg;
    logic [23:0] release_reg;
    logic [15:0] drift_reg;
    logic        loop_reg;
    logic [24:0] silence_reg;
    logic [23:0] quick_reg;

    // Envelope state.
    logic [LVL_W-1:0] level_reg;
    logic             aim_reg;
    logic [23:0]      pole_reg;
    logic [1:0]       stage_reg;
    logic [23:0]      rel_now_reg;

    // Sequencer and drift working registers.
    seq_state_t  state_reg, state_next;
    logic [23:0] base_reg;
    logic        adopt_reg;
    logic        pend_att_reg;
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [13:0] depth_reg;
    logic [16:0] ex_reg;
    logic [23:0] mant_reg;
    logic [4:0]  zc_reg;
    logic [15:0] frac_reg;
    logic [21:0] prod_reg;
    logic [30:0] acc_reg;
    logic [3:0]  step_reg;
    logic [23:0] dres_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    // Shared arithmetic.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    rng_ctl_t    rng_ctl;
    logic [31:0] rnd_next;

    lare_mul u_mul (
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    lare_rng u_rng (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rng_ctl),
        .rnd_next (rnd_next)
    );

    // Tick operand: distance to the top when aiming there, else the level itself.
    logic [LVL_W-1:0] tick_dist;
    logic [LVL_W-1:0] tick_opnd;
    logic [LVL_W-1:0] tick_scaled;
    logic [LVL_W-1:0] tick_level;

    always_comb begin
        tick_dist   = (level_reg < LVL_TOP) ? (LVL_TOP - level_reg) : '0;
        tick_opnd   = aim_reg ? tick_dist : level_reg;
        tick_scaled = mul_p[MULT_W +: LVL_W];
        tick_level  = aim_reg ? (LVL_TOP - tick_scaled) : tick_scaled;
    end

    // Stage decisions after a tick has moved the level.
    logic             lvl_silent;
    logic             ends_attack;
    logic [1:0]       stage_a;
    logic             rel_silent;
    logic [1:0]       stage_b;
    logic             need_att;
    logic [1:0]       stage_fin;

    always_comb begin
        lvl_silent  = level_reg <= LVL_W'(silence_reg);
        ends_attack = (stage_reg == STAGE_ATTACK) && (level_reg >= LVL_ONE);
        stage_a     = ends_attack ? STAGE_RELEASE : stage_reg;
        rel_silent  = (stage_a == STAGE_RELEASE) && lvl_silent;
        stage_b     = rel_silent ? (loop_reg ? STAGE_ATTACK : STAGE_IDLE) : stage_a;
        need_att    = (rel_silent && loop_reg)
                   || ((stage_b == STAGE_IDLE) && loop_reg && lvl_silent);
        stage_fin   = need_att ? STAGE_ATTACK : stage_b;
    end

    // Drift arithmetic taps.
    logic        rnd_neg;
    logic [31:0] rnd_mag;
    logic [15:0] rd_val;
    logic [24:0] sq_val;
    logic [20:0] nlog;
    logic [5:0]  exp_q;
    logic [30:0] exp_shift;
    logic [23:0] exp_res;
    logic [23:0] drift_pole;

    always_comb begin
        rnd_neg    = ~rnd_next[31];
        rnd_mag    = rnd_neg ? (32'h8000_0000 - rnd_next) : (rnd_next - 32'h8000_0000);
        rd_val     = mul_p[46:31];
        sq_val     = mul_p[47:23];
        nlog       = 21'((22'(zc_reg) + 22'd1) << 16) - 21'(frac_reg);
        exp_q      = prod_reg[21:16];
        exp_shift  = acc_reg >> (5'(exp_q) + 5'd6);
        if (exp_q >= 6'd25) begin
            exp_res = '0;
        end else if (exp_shift[30:24] != '0) begin
            exp_res = MULT_SAT;
        end else begin
            exp_res = exp_shift[23:0];
        end
        drift_pole = (adopt_reg && (dres_reg >= ADOPT_CAP)) ? ADOPT_CAP : dres_reg;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.action)
                        ACT_TICK:    state_next = ST_TICK_MUL;
                        ACT_ATTACK,
                        ACT_RELEASE: state_next = ST_DR_START;
                        ACT_ADOPT:   state_next = aim_reg ? ST_DONE : ST_DR_START;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_TICK_MUL: state_next = ST_TICK_FIN;
            ST_TICK_FIN: state_next = (ends_attack || need_att) ? ST_DR_START : ST_DONE;
            ST_DR_START: begin
                if (drift_reg == '0 || base_reg == '0) begin
                    state_next = ST_DR_APPLY;
                end else begin
                    state_next = ST_DR_DEPTH;
                end
            end
            ST_DR_DEPTH: state_next = ST_DR_RD;
            ST_DR_RD:    state_next = ST_DR_NORM;
            ST_DR_NORM:  state_next = mant_reg[23] ? ST_DR_LOG : ST_DR_NORM;
            ST_DR_LOG:   state_next = (step_reg == '0) ? ST_DR_PROD : ST_DR_LOG;
            ST_DR_PROD:  state_next = ST_DR_EXP;
            ST_DR_EXP:   state_next = (step_reg == '0) ? ST_DR_FIN : ST_DR_EXP;
            ST_DR_FIN:   state_next = ST_DR_APPLY;
            ST_DR_APPLY: state_next = pend_att_reg ? ST_DR_START : ST_DONE;
            ST_DONE:     state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, generator control, input ready.
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        rng_ctl.load = cfg_wr_en && (cfg_addr == REG_SEED);
        rng_ctl.seed = cfg_wdata;
        rng_ctl.step = (state_reg == ST_DR_START) && (drift_reg != '0);
        s_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_TICK_MUL: begin
                mul_a = 32'(pole_reg);
                mul_b = 32'(tick_opnd);
            end
            ST_DR_DEPTH: begin
                mul_a = 32'(drift_reg);
                mul_b = 32'(DRIFT_SCALE);
            end
            ST_DR_RD: begin
                mul_a = mag_reg;
                mul_b = 32'(depth_reg);
            end
            ST_DR_LOG: begin
                mul_a = 32'(mant_reg);
                mul_b = 32'(mant_reg);
            end
            ST_DR_PROD: begin
                mul_a = 32'(nlog);
                mul_b = 32'(ex_reg);
            end
            ST_DR_EXP: begin
                mul_a = 32'(acc_reg);
                mul_b = 32'(EXP_ROOT[~step_reg]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control state, configuration and envelope registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            attack_reg   <= ATTACK_RST;
            release_reg  <= RELEASE_RST;
            drift_reg    <= '0;
            loop_reg     <= 1'b0;
            silence_reg  <= SILENCE_RST;
            quick_reg    <= QUICK_RST;
            level_reg    <= '0;
            aim_reg      <= 1'b0;
            pole_reg     <= '0;
            stage_reg    <= STAGE_IDLE;
            rel_now_reg  <= RELEASE_RST;
            pend_att_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ATTACK:  attack_reg <= cfg_wdata[23:0];
                    REG_RELEASE: begin
                        release_reg <= cfg_wdata[23:0];
                        rel_now_reg <= cfg_wdata[23:0];
                    end
                    REG_DRIFT:   drift_reg   <= cfg_wdata[15:0];
                    REG_LOOP:    loop_reg    <= cfg_wdata[0];
                    REG_SILENCE: silence_reg <= cfg_wdata[24:0];
                    REG_QUICK:   quick_reg   <= cfg_wdata[23:0];
                    default:     ;
                endcase
            end

            // In the final state a taken result is replaced by the new one below.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        pend_att_reg <= 1'b0;
                        case (s_data.action)
                            ACT_ATTACK: begin
                                stage_reg <= STAGE_ATTACK;
                                aim_reg   <= 1'b1;
                            end
                            ACT_RELEASE: begin
                                stage_reg <= STAGE_RELEASE;
                                aim_reg   <= 1'b0;
                            end
                            ACT_RESET: begin
                                level_reg <= '0;
                                aim_reg   <= 1'b0;
                                pole_reg  <= '0;
                                stage_reg <= STAGE_IDLE;
                            end
                            ACT_QUICK: begin
                                aim_reg  <= 1'b0;
                                pole_reg <= quick_reg;
                            end
                            ACT_ADOPT: rel_now_reg <= s_data.new_release_mult;
                            default:   ;
                        endcase
                    end
                end
                ST_TICK_MUL: level_reg <= tick_level;
                ST_TICK_FIN: begin
                    stage_reg <= stage_fin;
                    if (need_att) begin
                        aim_reg <= 1'b1;
                    end else if (ends_attack) begin
                        aim_reg <= 1'b0;
                    end
                    // When the attack ends, the release drift runs first.
                    pend_att_reg <= ends_attack && need_att;
                end
                ST_DR_APPLY: begin
                    pole_reg     <= drift_pole;
                    pend_att_reg <= 1'b0;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Drift working registers and the output register hold payload only.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                case (s_data.action)
                    ACT_ATTACK: begin
                        base_reg  <= attack_reg;
                        adopt_reg <= 1'b0;
                    end
                    ACT_ADOPT: begin
                        base_reg  <= s_data.new_release_mult;
                        adopt_reg <= 1'b1;
                    end
                    default: begin
                        base_reg  <= rel_now_reg;
                        adopt_reg <= 1'b0;
                    end
                endcase
            end
            ST_TICK_FIN: begin
                base_reg  <= ends_attack ? rel_now_reg : attack_reg;
                adopt_reg <= 1'b0;
            end
            ST_DR_START: begin
                // No drift passes the base through; a zero base drifts to zero.
                dres_reg <= (drift_reg == '0) ? base_reg : '0;
                neg_reg  <= rnd_neg;
                mag_reg  <= rnd_mag;
                mant_reg <= base_reg;
                zc_reg   <= '0;
                frac_reg <= '0;
            end
            ST_DR_DEPTH: depth_reg <= mul_p[29:16];
            ST_DR_RD: begin
                ex_reg   <= neg_reg ? (17'h10000 - 17'(rd_val)) : (17'h10000 + 17'(rd_val));
                step_reg <= 4'd15;
            end
            ST_DR_NORM: begin
                if (!mant_reg[23]) begin
                    mant_reg <= mant_reg << 1;
                    zc_reg   <= zc_reg + 5'd1;
                end
            end
            ST_DR_LOG: begin
                if (sq_val[24]) begin
                    mant_reg           <= sq_val[24:1];
                    frac_reg[step_reg] <= 1'b1;
                end else begin
                    mant_reg <= sq_val[23:0];
                end
                step_reg <= step_reg - 4'd1;
            end
            ST_DR_PROD: begin
                prod_reg <= mul_p[37:16];
                acc_reg  <= 31'h4000_0000;
                step_reg <= 4'd15;
            end
            ST_DR_EXP: begin
                if (prod_reg[step_reg]) begin
                    acc_reg <= mul_p[60:30];
                end
                step_reg <= step_reg - 4'd1;
            end
            ST_DR_FIN: dres_reg <= exp_res;
            ST_DR_APPLY: begin
                base_reg  <= attack_reg;
                adopt_reg <= 1'b0;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.level_out <= level_reg;
                    m_data_reg.stage_out <= stage_reg;
                    m_data_reg.active    <= level_reg > LVL_W'(silence_reg);
                    m_data_reg.in_attack <= stage_reg == STAGE_ATTACK;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A taken beat always starts sequencer work, so ready drops right after.
    `LARE_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // The level never passes the attack target.
    `LARE_ASSERT_IMP(a_level_bounded, 1'b1, level_reg <= LVL_TOP)
    // The stage register never holds the unused code.
    `LARE_ASSERT_IMP(a_stage_legal, 1'b1, stage_reg != 2'd3)
    // The attack flag in a result agrees with its stage.
    `LARE_ASSERT_IMP(a_attack_flag, m_valid,
        m_data.in_attack == (m_data.stage_out == STAGE_ATTACK))

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the looping attack/release envelope with random pole drift.
module tb_top;
    import lare_pkg::*;

    // Action codes that the block must ignore, reporting its state unchanged.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // Cycles allowed for the block to settle before a register write or the end.
    localparam int SETTLE_CYCLES = 200;
    // Length of the one long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 500;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    looping_ar_envelope_with_drift u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 10 time unit clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every input is known from time zero.
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
    end

    // Copy of the envelope state and its registers, kept by the predictor.
    logic [23:0] cfg_attack;
    logic [23:0] cfg_release;
    logic [15:0] cfg_drift;
    logic        cfg_loop;
    logic [24:0] cfg_silence;
    logic [23:0] cfg_quick;
    logic [31:0] cfg_seed;
    logic [63:0] lvl;
    logic        aim_top;
    logic [23:0] pole;
    logic [1:0]  stage;
    logic [23:0] rel_now;
    logic [31:0] rng;

    out_item_t level_queue[$];
    int        fail_count = 0;
    int        beats_out  = 0;
    bit        calm       = 1'b0;

    function automatic void model_reset();
        cfg_attack  = ATTACK_RST;
        cfg_release = RELEASE_RST;
        cfg_drift   = 16'd0;
        cfg_loop    = 1'b0;
        cfg_silence = SILENCE_RST;
        cfg_quick   = QUICK_RST;
        cfg_seed    = SEED_RST;
        lvl         = 64'd0;
        aim_top     = 1'b0;
        pole        = 24'd0;
        stage       = STAGE_IDLE;
        rel_now     = cfg_release;
        rng         = cfg_seed;
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_ATTACK:  cfg_attack = val[23:0];
            REG_RELEASE: begin
                cfg_release = val[23:0];
                rel_now     = val[23:0];
            end
            REG_DRIFT:   cfg_drift = val[15:0];
            REG_LOOP:    cfg_loop = val[0];
            REG_SILENCE: cfg_silence = val[24:0];
            REG_QUICK:   cfg_quick = val[23:0];
            REG_SEED: begin
                cfg_seed = val;
                rng      = val;
            end
            default: ;
        endcase
    endfunction

    // Floor square root by trial of each result bit from the top.
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // -log2 of a Q0.24 multiplier, in Q.16.
    function automatic logic [63:0] minus_log2(logic [23:0] m);
        int          p;
        logic [63:0] mant;
        logic [15:0] frac;
        p    = 23;
        frac = 16'd0;
        while (p > 0 && !m[p]) p--;
        mant = 64'(m) << (23 - p);
        for (int i = 15; i >= 0; i--) begin
            mant = (mant * mant) >> 23;
            if (mant >= (64'd1 << 24)) begin
                mant    = mant >> 1;
                frac[i] = 1'b1;
            end
        end
        return 64'(24 - p) * 64'd65536 - 64'(frac);
    endfunction

    // 2^-x for x in Q.16, returned as a saturated Q0.24 multiplier.
    function automatic logic [23:0] pow2_neg(logic [63:0] x);
        logic [63:0] whole;
        logic [63:0] acc;
        logic [63:0] fac;
        logic [63:0] r;
        whole = x >> 16;
        acc   = 64'd1 << 30;
        fac   = 64'd1 << 29;
        for (int i = 15; i >= 0; i--) begin
            fac = floor_root(fac << 30);
            if (x[i]) acc = (acc * fac) >> 30;
        end
        if (whole + 6 >= 40) return 24'd0;
        r = acc >> (whole + 6);
        return (r > 64'hFFFFFF) ? MULT_SAT : r[23:0];
    endfunction

    // Pole after drift; the xorshift state steps whenever drift is enabled.
    function automatic logic [23:0] drifted_pole(logic [23:0] base);
        logic [31:0] s;
        logic [63:0] mag;
        logic [63:0] depth;
        logic [63:0] rd;
        logic [63:0] ex;
        logic        below;
        if (cfg_drift == 16'd0) return base;
        s   = rng;
        s   = s ^ (s << 13);
        s   = s ^ (s >> 17);
        s   = s ^ (s << 5);
        rng = s;
        if (base == 24'd0) return 24'd0;
        below = s < 32'h8000_0000;
        mag   = below ? 64'(32'h8000_0000 - s) : 64'(s - 32'h8000_0000);
        depth = (64'(cfg_drift) * 64'(DRIFT_SCALE)) >> 16;
        rd    = (mag * depth) >> 31;
        ex    = below ? 64'd65536 - rd : 64'd65536 + rd;
        return pow2_neg((minus_log2(base) * ex) >> 16);
    endfunction

    function automatic void begin_attack();
        stage   = STAGE_ATTACK;
        aim_top = 1'b1;
        pole    = drifted_pole(cfg_attack);
    endfunction

    function automatic void begin_release();
        stage   = STAGE_RELEASE;
        aim_top = 1'b0;
        pole    = drifted_pole(rel_now);
    endfunction

    // Expected level and flags after one accepted action.
    function automatic out_item_t envelope_next(logic [2:0] act, logic [23:0] nm);
        logic [63:0] top;
        logic [63:0] gap;
        logic [23:0] p;
        out_item_t   o;
        top = 64'd2 << FRAC_BITS;
        case (act)
            ACT_TICK: begin
                if (aim_top) begin
                    gap = (lvl < top) ? top - lvl : 64'd0;
                    lvl = top - ((64'(pole) * gap) >> 24);
                end else begin
                    lvl = (64'(pole) * lvl) >> 24;
                end
                if (stage == STAGE_ATTACK && lvl >= (64'd1 << FRAC_BITS)) begin_release();
                if (stage == STAGE_RELEASE && lvl <= 64'(cfg_silence)) begin
                    if (cfg_loop) begin_attack();
                    else stage = STAGE_IDLE;
                end
                if (stage == STAGE_IDLE && cfg_loop && lvl <= 64'(cfg_silence)) begin_attack();
            end
            ACT_ATTACK:  begin_attack();
            ACT_RELEASE: begin_release();
            ACT_RESET: begin
                lvl     = 64'd0;
                aim_top = 1'b0;
                pole    = 24'd0;
                stage   = STAGE_IDLE;
            end
            ACT_QUICK: begin
                aim_top = 1'b0;
                pole    = cfg_quick;
            end
            ACT_ADOPT: begin
                rel_now = nm;
                if (!aim_top) begin
                    p    = drifted_pole(nm);
                    pole = (p < ADOPT_CAP) ? p : ADOPT_CAP;
                end
            end
            default: ;
        endcase
        o.level_out = lvl[25:0];
        o.stage_out = stage;
        o.active    = lvl > 64'(cfg_silence);
        o.in_attack = stage == STAGE_ATTACK;
        return o;
    endfunction

    // One beat on the input channel, with random idle cycles in front of it.
    // The predictor runs at the accepting edge; a row with a typed expectation
    // queues that value instead of the prediction.
    task automatic send_beat(logic [2:0] act, logic [23:0] nm, bit typed, out_item_t typed_exp);
        in_item_t  it;
        out_item_t pred;
        it.action           = act;
        it.new_release_mult = nm;
        while (!calm && $urandom_range(99) < 21) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = envelope_next(act, nm);
        level_queue.push_back(typed ? typed_exp : pred);
    endtask

    typedef struct {
        logic [23:0] atk;
        logic [23:0] rel;
        logic [15:0] drift;
        logic        loop_on;
        logic [24:0] sil;
        logic [23:0] quick;
        logic [31:0] seed;
    } env_cfg_t;

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        model_write(idx, val);
    endtask

    // Writes are made only with the block idle: the sender is parked, every
    // result is in, and the block has had time to finish any drift work.
    task automatic apply_config(env_cfg_t c);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (level_queue.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_ATTACK,  32'(c.atk));
        write_reg(REG_RELEASE, 32'(c.rel));
        write_reg(REG_DRIFT,   32'(c.drift));
        write_reg(REG_LOOP,    32'(c.loop_on));
        write_reg(REG_SILENCE, 32'(c.sil));
        write_reg(REG_QUICK,   32'(c.quick));
        write_reg(REG_SEED,    c.seed);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random action mix: mostly ticks so the stages really run, with a share
    // of triggers, adopts and unused codes mixed in.
    function automatic logic [2:0] pick_action();
        int w;
        w = $urandom_range(99);
        if (w < 58) return ACT_TICK;
        if (w < 68) return ACT_ATTACK;
        if (w < 76) return ACT_RELEASE;
        if (w < 80) return ACT_RESET;
        if (w < 86) return ACT_QUICK;
        if (w < 96) return ACT_ADOPT;
        return (w < 98) ? ACT_SPARE_6 : ACT_SPARE_7;
    endfunction

    // Release multipliers from the whole range, near the cap, and small ones.
    function automatic logic [23:0] pick_mult();
        case ($urandom_range(3))
            0, 1: return 24'($urandom);
            2:    return 24'hFFF000 | 24'($urandom_range(12'hFFF));
            default: return 24'($urandom_range(24'h3FFFFF));
        endcase
    endfunction

    // Directed rows: action, release multiplier, whether the result is typed in.
    typedef struct {
        logic [2:0]  act;
        logic [23:0] nm;
        bit          typed;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    dir_row_t  dir_tab [DIR_ROWS];
    env_cfg_t  phase_tab [8];
    out_item_t zero_item;

    initial begin
        zero_item = '0;
        // After reset nothing moves: a tick, the unused codes and a reset all read zero.
        dir_tab[0]  = '{ACT_TICK,    24'h000000, 1'b1};
        dir_tab[1]  = '{ACT_SPARE_6, 24'hFFFFFF, 1'b1};
        dir_tab[2]  = '{ACT_SPARE_7, 24'hFFFFFF, 1'b1};
        dir_tab[3]  = '{ACT_RESET,   24'h000000, 1'b1};
        // Attack, then a quick release that leaves the stage at attack.
        dir_tab[4]  = '{ACT_ATTACK,  24'h000000, 1'b0};
        dir_tab[5]  = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[6]  = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[7]  = '{ACT_QUICK,   24'h000000, 1'b0};
        dir_tab[8]  = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[9]  = '{ACT_TICK,    24'h000000, 1'b0};
        // Adopt while aiming at zero: the largest multiplier is capped.
        dir_tab[10] = '{ACT_RELEASE, 24'h000000, 1'b0};
        dir_tab[11] = '{ACT_ADOPT,   24'hFFFFFF, 1'b0};
        dir_tab[12] = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[13] = '{ACT_ADOPT,   24'h000000, 1'b0};
        dir_tab[14] = '{ACT_TICK,    24'h000000, 1'b0};
        // Attack runs through to release at one and decays with the adopted multiplier.
        dir_tab[15] = '{ACT_ATTACK,  24'h000000, 1'b0};
        dir_tab[16] = '{ACT_ADOPT,   24'h123456, 1'b0};
        dir_tab[17] = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[18] = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[19] = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[20] = '{ACT_RELEASE, 24'h000000, 1'b0};
        dir_tab[21] = '{ACT_TICK,    24'h000000, 1'b0};
        dir_tab[22] = '{ACT_RESET,   24'h000000, 1'b1};
        dir_tab[23] = '{ACT_TICK,    24'h000000, 1'b1};

        // Random phase settings; every extreme appears but the silence maximum.
        phase_tab[0] = '{24'hC00000, 24'hC00000, 16'h0000, 1'b1, 25'd17,
                         24'h400000, SEED_RST};
        phase_tab[1] = '{24'h900000, 24'hA00000, 16'hFFFF, 1'b1, 25'd4096,
                         24'h200000, 32'hFFFF_FFFF};
        phase_tab[2] = '{24'h000000, 24'hFFFFFF, 16'h8000, 1'b0, 25'd0,
                         24'h000000, 32'h0000_0000};
        phase_tab[3] = '{24'hE00000, 24'h800000, 16'h0000, 1'b1, 25'd16777216,
                         24'hFFFFFF, 32'h1234_5678};
        phase_tab[4] = '{24'hFFFFFF, 24'h000000, 16'h0001, 1'b1, 25'd1000,
                         24'h100000, 32'hDEAD_BEEF};
        phase_tab[5] = '{24'hA00000, 24'hD00000, 16'h4000, 1'b0, 25'd100000,
                         24'h800000, 32'h0000_0001};
        phase_tab[6] = '{24'hF00000, 24'hF00000, 16'hFFFF, 1'b1, 25'd65536,
                         24'hC00000, 32'h8000_0000};
        phase_tab[7] = '{24'h800000, 24'h900000, 16'h0000, 1'b1, 25'd17,
                         24'h300000, SEED_RST};
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        model_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apply_config('{24'hC00000, 24'hC00000, 16'h0000, 1'b0, 25'd17,
                       24'h400000, SEED_RST});
        for (int r = 0; r < DIR_ROWS; r++)
            send_beat(dir_tab[r].act, dir_tab[r].nm, dir_tab[r].typed, zero_item);

        for (int ph = 0; ph < 8; ph++) begin
            apply_config(phase_tab[ph]);
            // One phase runs with no idling on either side.
            calm = (ph == 3);
            for (int n = 0; n < 125; n++)
                send_beat(pick_action(), pick_mult(), 1'b0, zero_item);
            calm = 1'b0;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (level_queue.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off once a few hundred
    // beats are out, so that the block backs up into its input.
    initial begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && beats_out >= 300) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
            end
        end
    end

    // Checker: every result beat against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out <= beats_out + 1;
            if (level_queue.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat %h", $time, m_data);
            end else begin
                want = level_queue.pop_front();
                if (m_data.level_out !== want.level_out) begin
                    fail_count++;
                    $display("%0t: level_out expected %h actual %h",
                             $time, want.level_out, m_data.level_out);
                end
                if (m_data.stage_out !== want.stage_out) begin
                    fail_count++;
                    $display("%0t: stage_out expected %0d actual %0d",
                             $time, want.stage_out, m_data.stage_out);
                end
                if (m_data.active !== want.active) begin
                    fail_count++;
                    $display("%0t: active expected %b actual %b",
                             $time, want.active, m_data.active);
                end
                if (m_data.in_attack !== want.in_attack) begin
                    fail_count++;
                    $display("%0t: in_attack expected %b actual %b",
                             $time, want.in_attack, m_data.in_attack);
                end
            end
        end
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
